// File: rtl/rpd_pkg.sv
// ----------------------------------------------------------------------------
// rpd_pkg
// Shared types and constants for the packet deframer with bit alignment.
// ----------------------------------------------------------------------------
package rpd_pkg;

   localparam logic [7:0] SYNC_WORD    = 8'h33;
   localparam logic [7:0] ALT_PREAMBLE = 8'h55;

   typedef enum logic [1:0] {
      EV_PAYLOAD  = 2'd0,
      EV_END      = 2'd1,
      EV_SYNC_ERR = 2'd2,
      EV_SIZE_ERR = 2'd3
   } event_kind_type;

   typedef enum logic [1:0] {
      CSR_PREAMBLE_VALUE = 2'd0,
      CSR_PREAMBLE_THRESH = 2'd1,
      CSR_MAX_LENGTH     = 2'd2,
      CSR_TRIPLE_LENGTH  = 2'd3
   } csr_index_type;

   typedef struct packed {
      event_kind_type event_kind;
      logic [7:0]     payload_byte;
      logic [7:0]     byte_index;
      logic [7:0]     packet_length;
      logic [15:0]    received_crc;
      logic [15:0]    sync_error_count;
      logic [15:0]    size_error_count;
   } result_type;

endpackage

// File: rtl/radio_packet_deframer_bit_align.sv
// ----------------------------------------------------------------------------
// radio_packet_deframer_bit_align
// Preamble and sync-byte packet deframer with bit re-alignment.
// ----------------------------------------------------------------------------
// Raw radio bytes enter on the req_ channel (valid/ready), one item each.
// Results leave on the rsp_ channel: payload bytes, packet end with the
// received CRC, sync errors and size errors, with saturating error totals.
// The csr_ port writes preamble value, preamble threshold, maximum length
// and triple-length mode; writes take effect on the next item.
// An accepted item lands in an input register; the state machine processes it
// from there once the result register is free or being taken and, if it
// causes a result, loads the result register. Throughput is one item per
// cycle while the receiver does not stall.
// When the receiver stalls, the result register holds its item, the input
// register fills, and req_ready drops only once both are occupied.
// Reset returns the framer to idle, clears error totals and loads the
// register defaults; no item is accepted during reset.
// ----------------------------------------------------------------------------
module radio_packet_deframer_bit_align
   import rpd_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_we,
   input  logic [1:0]  csr_index,
   input  logic [7:0]  csr_data,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_rx_byte,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [1:0]  rsp_event_kind,
   output logic [7:0]  rsp_payload_byte,
   output logic [7:0]  rsp_byte_index,
   output logic [7:0]  rsp_packet_length,
   output logic [15:0] rsp_received_crc,
   output logic [15:0] rsp_sync_error_count,
   output logic [15:0] rsp_size_error_count
);

   logic       in_valid_ff;
   logic [7:0] in_byte_ff;
   logic       in_take;
   result_type rsp_item;

   assign req_ready = !reset && (!in_valid_ff || in_take);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= (req_valid && req_ready) || (in_valid_ff && !in_take);
      end
      if (req_valid && req_ready) begin
         in_byte_ff <= req_rx_byte;
      end
   end

   rpd_core u_core (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .in_valid  (in_valid_ff),
      .in_byte   (in_byte_ff),
      .in_take   (in_take),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_item  (rsp_item)
   );

   assign rsp_event_kind       = rsp_item.event_kind;
   assign rsp_payload_byte     = rsp_item.payload_byte;
   assign rsp_byte_index       = rsp_item.byte_index;
   assign rsp_packet_length    = rsp_item.packet_length;
   assign rsp_received_crc     = rsp_item.received_crc;
   assign rsp_sync_error_count = rsp_item.sync_error_count;
   assign rsp_size_error_count = rsp_item.size_error_count;

endmodule

// File: rtl/rpd_core.sv
// ----------------------------------------------------------------------------
// rpd_core
// Deframer state machine, sync search, re-alignment and result register.
// ----------------------------------------------------------------------------
module rpd_core
   import rpd_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         csr_we,
   input  logic [1:0]   csr_index,
   input  logic [7:0]   csr_data,
   input  logic         in_valid,
   input  logic [7:0]   in_byte,
   output logic         in_take,
   output logic         rsp_valid,
   input  logic         rsp_ready,
   output result_type   rsp_item
);

   typedef enum logic [2:0] {
      PH_IDLE  = 3'd0,
      PH_PRE   = 3'd1,
      PH_SYNC  = 3'd2,
      PH_SIZE  = 3'd3,
      PH_DATA  = 3'd4,
      PH_CRC_H = 3'd5,
      PH_CRC_L = 3'd6
   } phase_type;

   phase_type   phase_ff, phase_in;
   logic [7:0]  prev_ff, prev_in;
   logic [2:0]  offset_ff, offset_in;
   logic [7:0]  pre_seen_ff, pre_seen_in;
   logic [7:0]  count_ff, count_in;
   logic [7:0]  length_ff, length_in;
   logic [7:0]  copy_ff [2];
   logic        copy_we;
   logic [7:0]  crc_hi_ff, crc_hi_in;
   logic [15:0] sync_err_ff, sync_err_in;
   logic [15:0] size_err_ff, size_err_in;

   logic [7:0]  pre_value_ff;
   logic [7:0]  pre_thresh_ff;
   logic [7:0]  max_len_ff;
   logic        triple_ff;

   logic        rsp_valid_ff, rsp_valid_in;
   result_type  rsp_ff, rsp_in;

   logic        step;
   logic        emit;
   logic [15:0] window;
   logic [15:0] shifted;
   logic [7:0]  aligned;
   logic        is_pre;
   logic [7:0]  match;
   logic [2:0]  found_k;
   logic [7:0]  len_val;

   assign step      = in_valid && (!rsp_valid_ff || rsp_ready);
   assign in_take   = step;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_ff;

   assign window  = {prev_ff, in_byte};
   assign shifted = window << offset_ff;
   assign aligned = shifted[15:8];
   assign is_pre  = (in_byte == pre_value_ff) || (in_byte == ALT_PREAMBLE);

   always_comb begin
      logic [15:0] w;
      found_k = 3'd0;
      for (int k = 7; k >= 0; k--) begin
         w = window << k;
         match[k] = (w[15:8] == SYNC_WORD);
         if (match[k]) begin
            found_k = 3'(k);
         end
      end
   end

   always_comb begin
      phase_in    = phase_ff;
      prev_in     = prev_ff;
      offset_in   = offset_ff;
      pre_seen_in = pre_seen_ff;
      count_in    = count_ff;
      length_in   = length_ff;
      copy_we     = 1'b0;
      crc_hi_in   = crc_hi_ff;
      sync_err_in = sync_err_ff;
      size_err_in = size_err_ff;
      emit        = 1'b0;
      len_val     = aligned;
      rsp_in      = '0;

      unique case (phase_ff)
         PH_PRE: begin
            if (!is_pre) begin
               if (pre_seen_ff > pre_thresh_ff) begin
                  phase_in  = PH_SYNC;
                  offset_in = 3'd0;
               end else begin
                  phase_in = PH_IDLE;
               end
            end else if (pre_seen_ff != 8'hFF) begin
               pre_seen_in = pre_seen_ff + 8'd1;
            end
            prev_in = in_byte;
         end
         PH_SYNC: begin
            if (match == 8'd0) begin
               if (sync_err_ff != 16'hFFFF) begin
                  sync_err_in = sync_err_ff + 16'd1;
               end
               phase_in          = PH_IDLE;
               emit              = 1'b1;
               rsp_in.event_kind = EV_SYNC_ERR;
            end else begin
               offset_in = found_k;
               phase_in  = PH_SIZE;
               prev_in   = in_byte;
               count_in  = 8'd0;
            end
         end
         PH_SIZE: begin
            prev_in = in_byte;
            if (triple_ff) begin
               len_val = (copy_ff[0] & copy_ff[1]) | (copy_ff[0] & aligned)
                       | (copy_ff[1] & aligned);
            end
            if (triple_ff && count_ff < 8'd2) begin
               copy_we  = 1'b1;
               count_in = count_ff + 8'd1;
            end else if (len_val == 8'd0 || len_val > max_len_ff) begin
               if (size_err_ff != 16'hFFFF) begin
                  size_err_in = size_err_ff + 16'd1;
               end
               phase_in          = PH_IDLE;
               emit              = 1'b1;
               rsp_in.event_kind = EV_SIZE_ERR;
            end else begin
               count_in  = 8'd0;
               length_in = len_val;
               phase_in  = PH_DATA;
            end
         end
         PH_DATA: begin
            prev_in  = in_byte;
            count_in = count_ff + 8'd1;
            if (count_in == length_ff) begin
               phase_in = PH_CRC_H;
            end
            emit                 = 1'b1;
            rsp_in.event_kind    = EV_PAYLOAD;
            rsp_in.payload_byte  = aligned;
            rsp_in.byte_index    = count_ff;
            rsp_in.packet_length = length_ff;
         end
         PH_CRC_H: begin
            crc_hi_in = aligned;
            prev_in   = in_byte;
            phase_in  = PH_CRC_L;
         end
         PH_CRC_L: begin
            prev_in              = in_byte;
            phase_in             = PH_IDLE;
            emit                 = 1'b1;
            rsp_in.event_kind    = EV_END;
            rsp_in.packet_length = length_ff;
            rsp_in.received_crc  = {crc_hi_ff, aligned};
         end
         default: begin
            phase_in = PH_IDLE;
            if (is_pre) begin
               pre_seen_in = 8'd0;
               phase_in    = PH_PRE;
            end
         end
      endcase

      rsp_in.sync_error_count = sync_err_in;
      rsp_in.size_error_count = size_err_in;

      if (step) begin
         rsp_valid_in = emit;
      end else begin
         rsp_valid_in = rsp_valid_ff && !rsp_ready;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= PH_IDLE;
         prev_ff       <= 8'd0;
         offset_ff     <= 3'd0;
         pre_seen_ff   <= 8'd0;
         count_ff      <= 8'd0;
         length_ff     <= 8'd0;
         crc_hi_ff     <= 8'd0;
         sync_err_ff   <= 16'd0;
         size_err_ff   <= 16'd0;
         pre_value_ff  <= 8'd170;
         pre_thresh_ff <= 8'd6;
         max_len_ff    <= 8'd64;
         triple_ff     <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         if (step) begin
            phase_ff    <= phase_in;
            prev_ff     <= prev_in;
            offset_ff   <= offset_in;
            pre_seen_ff <= pre_seen_in;
            count_ff    <= count_in;
            length_ff   <= length_in;
            crc_hi_ff   <= crc_hi_in;
            sync_err_ff <= sync_err_in;
            size_err_ff <= size_err_in;
         end
         if (csr_we) begin
            unique case (csr_index_type'(csr_index))
               CSR_PREAMBLE_VALUE:  pre_value_ff  <= csr_data;
               CSR_PREAMBLE_THRESH: pre_thresh_ff <= csr_data;
               CSR_MAX_LENGTH:      max_len_ff    <= csr_data;
               CSR_TRIPLE_LENGTH:   triple_ff     <= csr_data[0];
               default:             ;
            endcase
         end
         rsp_valid_ff <= rsp_valid_in;
      end
      if (step && emit) begin
         rsp_ff <= rsp_in;
      end
      if (step && copy_we) begin
         copy_ff[count_ff[0]] <= aligned;
      end
   end

endmodule

// File: bench/deframer_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// deframer_checker
// Watches the byte, result and register ports of the deframer, runs its own
// model of the framing state machine on every accepted byte, and compares
// each result item field by field with the oldest predicted event.
// ----------------------------------------------------------------------------
module deframer_checker
   import rpd_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_we,
   input  logic [1:0]  csr_index,
   input  logic [7:0]  csr_data,
   input  logic        req_valid,
   input  logic        req_ready,
   input  logic [7:0]  req_rx_byte,
   input  logic        rsp_valid,
   input  logic        rsp_ready,
   input  logic [1:0]  rsp_event_kind,
   input  logic [7:0]  rsp_payload_byte,
   input  logic [7:0]  rsp_byte_index,
   input  logic [7:0]  rsp_packet_length,
   input  logic [15:0] rsp_received_crc,
   input  logic [15:0] rsp_sync_error_count,
   input  logic [15:0] rsp_size_error_count,
   output int          fail_count,
   output int          outstanding
);

   typedef enum logic [2:0] {
      FR_IDLE,
      FR_PREAMBLE,
      FR_SYNC,
      FR_LENGTH,
      FR_DATA,
      FR_CRC_HI,
      FR_CRC_LO
   } frame_phase_type;

   logic [7:0]      cfg_pre;
   logic [7:0]      cfg_thresh;
   logic [7:0]      cfg_max_len;
   logic            cfg_triple;

   frame_phase_type fr_phase;
   logic [7:0]      prev_raw;
   logic [2:0]      shift;
   logic [7:0]      seen;
   logic [7:0]      cnt;
   logic [7:0]      len_held;
   logic [7:0]      copies [2];
   logic [7:0]      crc_hi;
   logic [15:0]     sync_total;
   logic [15:0]     size_total;

   result_type      events_due [$];
   int              mismatches = 0;

   function automatic bit is_preamble(input logic [7:0] b);
      return b == cfg_pre || b == ALT_PREAMBLE;
   endfunction

   function automatic logic [7:0] realign(input logic [7:0] cur);
      logic [15:0] w;
      w = {prev_raw, cur} << shift;
      return w[15:8];
   endfunction

   task automatic deframe_byte(input logic [7:0] cur, output bit emits,
                               output result_type ev);
      logic [7:0]  v;
      logic [15:0] win;
      int          hit;
      emits = 1'b0;
      ev    = '0;
      case (fr_phase)
         FR_PREAMBLE: begin
            if (!is_preamble(cur)) begin
               if (seen > cfg_thresh) begin
                  fr_phase = FR_SYNC;
                  shift    = 3'd0;
               end else begin
                  fr_phase = FR_IDLE;
               end
            end else if (seen != 8'hFF) begin
               seen++;
            end
            prev_raw = cur;
         end
         FR_SYNC: begin
            hit = -1;
            for (int k = 7; k >= 0; k--) begin
               win = {prev_raw, cur} << k;
               if (win[15:8] == SYNC_WORD) hit = k;
            end
            if (hit < 0) begin
               if (sync_total != 16'hFFFF) sync_total++;
               fr_phase      = FR_IDLE;
               emits         = 1'b1;
               ev.event_kind = EV_SYNC_ERR;
            end else begin
               shift    = 3'(hit);
               fr_phase = FR_LENGTH;
               prev_raw = cur;
               cnt      = 8'd0;
            end
         end
         FR_LENGTH: begin
            v        = realign(cur);
            prev_raw = cur;
            if (cfg_triple && cnt < 8'd2) begin
               copies[cnt[0]] = v;
               cnt++;
            end else begin
               if (cfg_triple)
                  v = (copies[0] & copies[1]) | (copies[0] & v) | (copies[1] & v);
               if (v == 8'd0 || v > cfg_max_len) begin
                  if (size_total != 16'hFFFF) size_total++;
                  fr_phase      = FR_IDLE;
                  emits         = 1'b1;
                  ev.event_kind = EV_SIZE_ERR;
               end else begin
                  cnt      = 8'd0;
                  len_held = v;
                  fr_phase = FR_DATA;
               end
            end
         end
         FR_DATA: begin
            emits            = 1'b1;
            ev.event_kind    = EV_PAYLOAD;
            ev.payload_byte  = realign(cur);
            ev.byte_index    = cnt;
            ev.packet_length = len_held;
            prev_raw         = cur;
            cnt++;
            if (cnt == len_held) fr_phase = FR_CRC_HI;
         end
         FR_CRC_HI: begin
            crc_hi   = realign(cur);
            prev_raw = cur;
            fr_phase = FR_CRC_LO;
         end
         FR_CRC_LO: begin
            emits            = 1'b1;
            ev.event_kind    = EV_END;
            ev.packet_length = len_held;
            ev.received_crc  = {crc_hi, realign(cur)};
            prev_raw         = cur;
            fr_phase         = FR_IDLE;
         end
         default: begin
            fr_phase = FR_IDLE;
            if (is_preamble(cur)) begin
               seen     = 8'd0;
               fr_phase = FR_PREAMBLE;
            end
         end
      endcase
      ev.sync_error_count = sync_total;
      ev.size_error_count = size_total;
   endtask

   task automatic check_field(input string name, input logic [15:0] want,
                              input logic [15:0] got);
      if (want !== got) begin
         $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
         mismatches++;
      end
   endtask

   always @(posedge clock) begin : monitor
      result_type due;
      result_type ev;
      bit         emits;
      if (reset) begin
         cfg_pre     = 8'd170;
         cfg_thresh  = 8'd6;
         cfg_max_len = 8'd64;
         cfg_triple  = 1'b0;
         fr_phase    = FR_IDLE;
         prev_raw    = 8'd0;
         shift       = 3'd0;
         seen        = 8'd0;
         cnt         = 8'd0;
         len_held    = 8'd0;
         crc_hi      = 8'd0;
         sync_total  = 16'd0;
         size_total  = 16'd0;
         events_due.delete();
      end else begin
         if (csr_we) begin
            case (csr_index_type'(csr_index))
               CSR_PREAMBLE_VALUE:  cfg_pre     = csr_data;
               CSR_PREAMBLE_THRESH: cfg_thresh  = csr_data;
               CSR_MAX_LENGTH:      cfg_max_len = csr_data;
               CSR_TRIPLE_LENGTH:   cfg_triple  = csr_data[0];
               default: ;
            endcase
         end
         if (rsp_valid && rsp_ready) begin
            if (events_due.size() == 0) begin
               $error("result item of kind %0d with nothing pending", rsp_event_kind);
               mismatches++;
            end else begin
               due = events_due.pop_front();
               check_field("event_kind", 16'(due.event_kind), 16'(rsp_event_kind));
               check_field("payload_byte", 16'(due.payload_byte), 16'(rsp_payload_byte));
               check_field("byte_index", 16'(due.byte_index), 16'(rsp_byte_index));
               check_field("packet_length", 16'(due.packet_length),
                           16'(rsp_packet_length));
               check_field("received_crc", due.received_crc, rsp_received_crc);
               check_field("sync_error_count", due.sync_error_count,
                           rsp_sync_error_count);
               check_field("size_error_count", due.size_error_count,
                           rsp_size_error_count);
            end
         end
         if (req_valid && req_ready) begin
            deframe_byte(req_rx_byte, emits, ev);
            if (emits) events_due.push_back(ev);
         end
      end
      outstanding <= events_due.size();
      fail_count  <= mismatches;
   end

endmodule

// File: bench/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Byte stream stimulus for the preamble/sync deframer: directed frames, then
// random framed traffic under several register settings with bit shifts of
// 0..7, triple length copies, bad lengths, failed syncs and line noise, a
// preamble run into the counter ceiling, and a closing stretch with no idle
// cycles. Prediction and comparison live in deframer_checker.
// ----------------------------------------------------------------------------
module tb_top;
   import rpd_pkg::*;

   localparam int unsigned CYCLE_LIMIT = 200_000;

   logic        clock;
   logic        reset       = 1'b1;
   logic        csr_we      = 1'b0;
   logic [1:0]  csr_index   = 2'd0;
   logic [7:0]  csr_data    = 8'd0;
   logic        req_valid   = 1'b0;
   logic [7:0]  req_rx_byte = 8'd0;
   logic        rsp_ready   = 1'b0;
   logic        req_ready;
   logic        rsp_valid;
   logic [1:0]  rsp_event_kind;
   logic [7:0]  rsp_payload_byte;
   logic [7:0]  rsp_byte_index;
   logic [7:0]  rsp_packet_length;
   logic [15:0] rsp_received_crc;
   logic [15:0] rsp_sync_error_count;
   logic [15:0] rsp_size_error_count;
   int          fail_count;
   int          outstanding;

   bit          idles_on    = 1'b1;
   int unsigned sent_items  = 0;
   int unsigned calm_items  = 0;
   int unsigned stall_left  = 0;
   int unsigned calm_cycles = 0;
   logic [7:0]  set_pre     = 8'd170;
   logic [7:0]  set_thr     = 8'd6;
   logic [7:0]  set_max     = 8'd64;
   logic        set_triple  = 1'b0;

   radio_packet_deframer_bit_align u_top (.*);

   deframer_checker u_check (.*);

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   always @(posedge clock) begin
      if (!idles_on) begin
         rsp_ready <= 1'b1;
      end else if (stall_left != 0) begin
         stall_left--;
         rsp_ready <= 1'b0;
      end else if (calm_cycles != 0) begin
         calm_cycles--;
         rsp_ready <= 1'b1;
      end else if ($urandom_range(0, 29) == 0) begin
         calm_cycles = $urandom_range(20, 80);
         rsp_ready <= 1'b1;
      end else if ($urandom_range(0, 4) == 0) begin
         stall_left = $urandom_range(0, 11);
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   task automatic send_byte(input logic [7:0] b);
      if (idles_on) begin
         if (calm_items != 0) begin
            calm_items--;
         end else if ($urandom_range(0, 24) == 0) begin
            calm_items = $urandom_range(8, 48);
         end else if ($urandom_range(0, 5) == 0) begin
            req_valid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge clock);
         end
      end
      req_valid   <= 1'b1;
      req_rx_byte <= b;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      sent_items++;
   endtask

   // hold off until every predicted event has been seen, then let the pipe empty
   task automatic settle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic apply_setup(input logic [7:0] pv, input logic [7:0] th,
                              input logic [7:0] ml, input logic tr);
      settle();
      csr_we    <= 1'b1;
      csr_index <= CSR_PREAMBLE_VALUE;
      csr_data  <= pv;
      @(posedge clock);
      csr_index <= CSR_PREAMBLE_THRESH;
      csr_data  <= th;
      @(posedge clock);
      csr_index <= CSR_MAX_LENGTH;
      csr_data  <= ml;
      @(posedge clock);
      csr_index <= CSR_TRIPLE_LENGTH;
      csr_data  <= {7'd0, tr};
      @(posedge clock);
      csr_we     <= 1'b0;
      set_pre    = pv;
      set_thr    = th;
      set_max    = ml;
      set_triple = tr;
   endtask

   task automatic send_preamble(input int n);
      repeat (n) send_byte($urandom_range(0, 1) ? set_pre : ALT_PREAMBLE);
   endtask

   // raw byte i carries the low k bits of frame byte i-1 and the top 8-k of byte i
   task automatic send_shifted(input int k, input logic [7:0] frame_bits[$]);
      logic [7:0] prior;
      logic [7:0] fresh;
      prior = 8'($urandom);
      for (int i = 0; i <= frame_bits.size(); i++) begin
         fresh = (i < frame_bits.size()) ? frame_bits[i] : 8'($urandom);
         send_byte(8'({prior, fresh} >> k));
         prior = fresh;
      end
   endtask

   task automatic send_frame(input bit bad_length);
      logic [7:0] seq[$];
      logic [7:0] len;
      logic [7:0] copy [3];
      int         pick;
      pick = $urandom_range(0, 9);
      if (bad_length)
         len = (set_max == 8'hFF || $urandom_range(0, 1)) ? 8'd0
               : 8'($urandom_range(set_max + 1, 255));
      else if (pick == 0)
         len = set_max;
      else if (pick == 1)
         len = 8'($urandom_range(1, set_max));
      else
         len = 8'($urandom_range(1, (set_max < 8'd12) ? set_max : 8'd12));
      seq.push_back(SYNC_WORD);
      if (set_triple) begin
         foreach (copy[i]) copy[i] = len;
         case ($urandom_range(0, 5))
            0: copy[$urandom_range(0, 2)] = 8'($urandom);
            1: foreach (copy[i]) copy[i] = 8'($urandom);
            default: ;
         endcase
         foreach (copy[i]) seq.push_back(copy[i]);
      end else begin
         seq.push_back(len);
      end
      if (!bad_length) repeat (int'(len) + 2) seq.push_back(8'($urandom));
      send_preamble(set_thr + 2 + $urandom_range(0, 2));
      send_shifted($urandom_range(0, 7), seq);
   endtask

   task automatic run_phase(input int unsigned quota);
      int unsigned stop_at;
      int          r;
      stop_at = sent_items + quota;
      while (sent_items < stop_at) begin
         r = $urandom_range(0, 19);
         if (r < 13) begin
            send_frame(1'b0);
         end else if (r < 15) begin
            send_frame(1'b1);
         end else if (r < 17) begin
            send_preamble(set_thr + 2 + $urandom_range(0, 1));
            repeat (2) send_byte(8'($urandom));
         end else if (r == 17) begin
            send_preamble(set_thr + 1);
            send_byte(8'($urandom));
         end else begin
            repeat ($urandom_range(1, 6)) send_byte(8'($urandom));
         end
         if ($urandom_range(0, 49) == 0) settle();
      end
   endtask

   initial begin : watchdog
      int unsigned n;
      n = 0;
      while (n < CYCLE_LIMIT) begin
         @(posedge clock);
         n++;
      end
      $display("radio_packet_deframer_bit_align regression: fail");
      $finish;
   end

   initial begin : stimulus
      logic [7:0] seq[$];
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      apply_setup(8'hAA, 8'd0, 8'd1, 1'b0);
      seq = '{SYNC_WORD, 8'h01, 8'hFF, 8'h00, 8'h00};
      send_byte(ALT_PREAMBLE);
      send_byte(8'hAA);
      send_shifted(0, seq);
      seq = '{SYNC_WORD, 8'h01, 8'h00, 8'hFF, 8'hFF};
      send_byte(8'hAA);
      send_byte(ALT_PREAMBLE);
      send_shifted(7, seq);
      seq = '{SYNC_WORD, 8'h02};
      send_byte(8'hAA);
      send_byte(8'hAA);
      send_shifted(5, seq);
      send_byte(ALT_PREAMBLE);
      send_byte(ALT_PREAMBLE);
      send_byte(8'h00);
      send_byte(8'h00);

      apply_setup(8'h00, 8'd0, 8'd255, 1'b1);
      run_phase(80);
      apply_setup(8'hFF, 8'd3, 8'd64, 1'b0);
      run_phase(80);
      apply_setup(ALT_PREAMBLE, 8'd1, 8'd1, 1'b1);
      run_phase(80);
      apply_setup(8'($urandom), 8'($urandom_range(0, 8)), 8'($urandom_range(1, 255)),
                  1'($urandom));
      run_phase(80);
      apply_setup(8'hAA, 8'd6, 8'd64, 1'b0);
      run_phase(80);
      apply_setup(8'($urandom), 8'd2, 8'd16, 1'b1);
      run_phase(80);

      // preamble counter runs into its ceiling
      apply_setup(8'hC3, 8'd254, 8'd20, 1'b0);
      send_frame(1'b0);

      idles_on = 1'b0;
      apply_setup(8'hAA, 8'd0, 8'd16, 1'b0);
      repeat (6) send_frame(1'($urandom));
      settle();

      if (fail_count == 0) begin
         $display("radio_packet_deframer_bit_align regression: pass");
      end else begin
         $display("radio_packet_deframer_bit_align regression: fail");
      end
      $finish;
   end

endmodule
